// ===== src/icrt_pkg.sv =====
// icrt_pkg: shared types and constants for the inode cache refcount table.
// No dependencies; used by the channel interfaces and the top level.
package icrt_pkg;

   localparam int DEV_W    = 8;
   localparam int INO_W    = 32;
   localparam int CNT_W    = 8;
   localparam int SLOTI_W  = 7;
   localparam int SLOTO_W  = 6;
   localparam int BLOCK_W  = 32;
   localparam int START_W  = 24;
   localparam int OFFSET_W = 3;
   localparam int STATUS_W = 3;

   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

   // request opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_HIT        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLAIM      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLEAN      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_WRITEBACK  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_HELD       = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PUT    = 3'd6;

   // one slot as stored in the table RAM
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [DEV_W-1:0] device;
      logic [INO_W-1:0] inode;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PUT_CHK,
      ST_LOCATE,
      ST_RESP
   } state_type;

endpackage

// ===== src/icrt_req_if.sv =====
// icrt_req_if: request channel (valid/ready plus request payload).
// Depends on icrt_pkg for field widths.
interface icrt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [icrt_pkg::DEV_W-1:0]    device_id;
   logic [icrt_pkg::INO_W-1:0]    inode_number;
   logic [icrt_pkg::SLOTI_W-1:0]  slot_index;
   logic                          dirty_flag;

   modport source (output valid, operation, device_id, inode_number, slot_index,
                   dirty_flag, input ready);
   modport sink   (input valid, operation, device_id, inode_number, slot_index,
                   dirty_flag, output ready);
endinterface

// ===== src/icrt_rsp_if.sv =====
// icrt_rsp_if: response channel (valid/ready plus result payload).
// Depends on icrt_pkg for field widths.
interface icrt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [icrt_pkg::STATUS_W-1:0]  status;
   logic [icrt_pkg::SLOTO_W-1:0]   slot_out;
   logic [icrt_pkg::BLOCK_W-1:0]   disk_block;
   logic [icrt_pkg::OFFSET_W-1:0]  inode_offset;

   modport source (output valid, status, slot_out, disk_block, inode_offset,
                   input ready);
   modport sink   (input valid, status, slot_out, disk_block, inode_offset,
                   output ready);
endinterface

// ===== src/icrt_ram.sv =====
// icrt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module icrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== src/inode_cache_refcount_table_top.sv =====
// inode_cache_refcount_table_top: reference-counted inode slot table.
// A get scans the slots until a hit or the last slot; a claim then locates the disk block.
// An out-of-range put goes straight to the result; other puts read their slot, and a
// write-back locates the block. One item at a time, accepted only once the result is taken.
// Reset (sync, high): clearing pass over all slots with req ready low; csr resets to 0.
// Depends on icrt_pkg, icrt_req_if, icrt_rsp_if and icrt_ram.
module inode_cache_refcount_table_top #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   icrt_req_if.sink                     req_chan,
   icrt_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [icrt_pkg::START_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam int ENTRY_W = $bits(icrt_pkg::slot_entry_type);

   // ---------------- registers ----------------
   icrt_pkg::state_type             state_ff, state_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;          // clear / scan read pointer
   logic [IDX_W-1:0]                chk_idx_ff, chk_idx_in;  // slot whose data is on rd_data
   logic                            chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]                free_idx_ff, free_idx_in; // lowest free slot seen
   logic                            free_vld_ff, free_vld_in;
   logic [icrt_pkg::DEV_W-1:0]      dev_ff, dev_in;
   logic [icrt_pkg::INO_W-1:0]      ino_ff, ino_in;
   logic                            dirty_ff, dirty_in;
   logic [IDX_W-1:0]                slot_ff, slot_in;
   logic [icrt_pkg::INO_W-1:0]      rel_ff, rel_in;           // inode number minus one
   logic [icrt_pkg::START_W-1:0]    start_ff;
   logic [icrt_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [icrt_pkg::SLOTO_W-1:0]    slot_out_ff, slot_out_in;
   logic [icrt_pkg::BLOCK_W-1:0]    block_ff, block_in;
   logic [icrt_pkg::OFFSET_W-1:0]   offset_ff, offset_in;

   // ---------------- table RAM ----------------
   logic                            ram_we;
   logic [IDX_W-1:0]                ram_waddr;
   icrt_pkg::slot_entry_type        ram_wdata;
   logic                            ram_re;
   logic [IDX_W-1:0]                ram_raddr;
   logic [ENTRY_W-1:0]              ram_rdata;
   icrt_pkg::slot_entry_type        entry;

   // scan / put helpers
   logic                            slot_hit;
   logic                            slot_free;
   logic                            claim_ok;
   logic [IDX_W-1:0]                claim_idx;
   logic [icrt_pkg::CNT_W-1:0]      count_dec;
   logic                            put_range_bad;

   icrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign entry = icrt_pkg::slot_entry_type'(ram_rdata);

   // a live slot with the same device and inode
   assign slot_hit  = (entry.count != '0) && (entry.device == dev_ff) && (entry.inode == ino_ff);
   assign slot_free = (entry.count == '0);
   // first free slot wins; the last slot counts if nothing earlier was free
   assign claim_ok  = free_vld_ff || slot_free;
   assign claim_idx = free_vld_ff ? free_idx_ff : chk_idx_ff;
   assign count_dec = entry.count - icrt_pkg::CNT_W'(1);
   assign put_range_bad = (32'(req_chan.slot_index) >= 32'(SLOT_COUNT));

   // ---------------- handshake / outputs ----------------
   assign req_chan.ready        = (state_ff == icrt_pkg::ST_IDLE);
   assign rsp_chan.valid        = (state_ff == icrt_pkg::ST_RESP);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.slot_out     = slot_out_ff;
   assign rsp_chan.disk_block   = block_ff;
   assign rsp_chan.inode_offset = offset_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = chk_vld_ff;
      free_idx_in = free_idx_ff;
      free_vld_in = free_vld_ff;
      dev_in      = dev_ff;
      ino_in      = ino_ff;
      dirty_in    = dirty_ff;
      slot_in     = slot_ff;
      rel_in      = rel_ff;
      status_in   = status_ff;
      slot_out_in = slot_out_ff;
      block_in    = block_ff;
      offset_in   = offset_ff;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = idx_ff;

      case (state_ff)
         icrt_pkg::ST_CLEAR: begin
            // zero one slot per cycle after reset
            ram_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = icrt_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         icrt_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               dev_in    = req_chan.device_id;
               ino_in    = req_chan.inode_number;
               dirty_in  = req_chan.dirty_flag;
               slot_in   = IDX_W'(req_chan.slot_index);
               block_in  = '0;
               offset_in = '0;
               if (req_chan.operation == icrt_pkg::OP_GET) begin
                  idx_in      = '0;
                  chk_vld_in  = 1'b0;
                  free_vld_in = 1'b0;
                  state_in    = icrt_pkg::ST_SCAN;
               end else if (put_range_bad) begin
                  status_in   = icrt_pkg::STATUS_BAD_PUT;
                  slot_out_in = '0;
                  state_in    = icrt_pkg::ST_RESP;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = IDX_W'(req_chan.slot_index);
                  state_in  = icrt_pkg::ST_PUT_CHK;
               end
            end
         end

         icrt_pkg::ST_SCAN: begin
            // read slot idx_ff while checking the slot read on the cycle before
            ram_re     = 1'b1;
            ram_raddr  = idx_ff;
            chk_idx_in = idx_ff;
            chk_vld_in = 1'b1;
            if (idx_ff != LAST_IDX) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            if (chk_vld_ff) begin
               if (slot_hit) begin
                  ram_we          = 1'b1;
                  ram_waddr       = chk_idx_ff;
                  ram_wdata       = entry;
                  if (entry.count != icrt_pkg::COUNT_MAX) begin
                     ram_wdata.count = entry.count + icrt_pkg::CNT_W'(1);
                  end
                  status_in   = icrt_pkg::STATUS_HIT;
                  slot_out_in = icrt_pkg::SLOTO_W'(chk_idx_ff);
                  state_in    = icrt_pkg::ST_RESP;
               end else begin
                  if (slot_free && !free_vld_ff) begin
                     free_idx_in = chk_idx_ff;
                     free_vld_in = 1'b1;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     if (claim_ok) begin
                        ram_we           = 1'b1;
                        ram_waddr        = claim_idx;
                        ram_wdata.count  = icrt_pkg::CNT_W'(1);
                        ram_wdata.device = dev_ff;
                        ram_wdata.inode  = ino_ff;
                        status_in        = icrt_pkg::STATUS_CLAIM;
                        slot_out_in      = icrt_pkg::SLOTO_W'(claim_idx);
                        rel_in           = ino_ff - icrt_pkg::INO_W'(1);
                        state_in         = icrt_pkg::ST_LOCATE;
                     end else begin
                        status_in   = icrt_pkg::STATUS_FULL;
                        slot_out_in = '0;
                        state_in    = icrt_pkg::ST_RESP;
                     end
                  end
               end
            end
         end

         icrt_pkg::ST_PUT_CHK: begin
            slot_out_in = icrt_pkg::SLOTO_W'(slot_ff);
            if (slot_free) begin
               // put to a slot nobody holds: leave it alone
               status_in = icrt_pkg::STATUS_BAD_PUT;
               state_in  = icrt_pkg::ST_RESP;
            end else begin
               ram_we          = 1'b1;
               ram_waddr       = slot_ff;
               ram_wdata       = entry;
               ram_wdata.count = count_dec;
               if (count_dec != '0) begin
                  status_in = icrt_pkg::STATUS_HELD;
                  state_in  = icrt_pkg::ST_RESP;
               end else if (!dirty_ff) begin
                  status_in = icrt_pkg::STATUS_CLEAN;
                  state_in  = icrt_pkg::ST_RESP;
               end else begin
                  status_in = icrt_pkg::STATUS_WRITEBACK;
                  rel_in    = entry.inode - icrt_pkg::INO_W'(1);
                  state_in  = icrt_pkg::ST_LOCATE;
               end
            end
         end

         icrt_pkg::ST_LOCATE: begin
            // eight inodes per block
            block_in  = (rel_ff >> 3) + icrt_pkg::BLOCK_W'(start_ff);
            offset_in = rel_ff[icrt_pkg::OFFSET_W-1:0];
            state_in  = icrt_pkg::ST_RESP;
         end

         icrt_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = icrt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = icrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= icrt_pkg::ST_CLEAR;
         idx_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         free_vld_ff <= 1'b0;
         start_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         chk_vld_ff  <= chk_vld_in;
         free_vld_ff <= free_vld_in;
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      dev_ff      <= dev_in;
      ino_ff      <= ino_in;
      dirty_ff    <= dirty_in;
      slot_ff     <= slot_in;
      rel_ff      <= rel_in;
      status_ff   <= status_in;
      slot_out_ff <= slot_out_in;
      block_ff    <= block_in;
      offset_ff   <= offset_in;
   end

   // ---------------- assertions ----------------
   // one item in flight: an accepted item drops ready on the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while an item is in flight");

   // never offer a result and take a request at once
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("ready and response valid together");

   // block and offset only carry data on claim or writeback
   a_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != icrt_pkg::STATUS_CLAIM
       && rsp_chan.status != icrt_pkg::STATUS_WRITEBACK)
      |-> (rsp_chan.disk_block == '0 && rsp_chan.inode_offset == '0))
      else $error("disk block set on a result that needs none");

   // a full table reports no slot
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == icrt_pkg::STATUS_FULL) |-> rsp_chan.slot_out == '0)
      else $error("full result with nonzero slot");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for inode_cache_refcount_table_top.
// Sends get/put items and checks every result against its row's typed result or a slot table kept in the bench.
// Depends on icrt_pkg, icrt_req_if, icrt_rsp_if and the top level.
module testbench;

   localparam int SLOT_COUNT       = 64;
   localparam int KEY_POOL         = 80;    // more keys than slots so the table can fill
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int NUM_DIRECTED     = 25;
   localparam int MAX_REPORTS      = 10;
   localparam bit EXP_TYPED        = 1'b1;  // row carries its own expected result
   localparam bit EXP_PREDICTED    = 1'b0;  // row is checked against the slot table

   typedef struct packed {
      logic                          op;
      logic [icrt_pkg::DEV_W-1:0]    dev;
      logic [icrt_pkg::INO_W-1:0]    ino;
      logic [icrt_pkg::SLOTI_W-1:0]  slot;
      logic                          dirty;
   } req_item_type;

   typedef struct packed {
      logic [icrt_pkg::STATUS_W-1:0] status;
      logic [icrt_pkg::SLOTO_W-1:0]  slot;
      logic [icrt_pkg::BLOCK_W-1:0]  block;
      logic [icrt_pkg::OFFSET_W-1:0] offset;
   } rsp_item_type;

   typedef struct packed {
      req_item_type rq;
      bit           typed;
      rsp_item_type rsp;
   } directed_row_type;

   // Directed items, table start at its reset value of zero, table empty.
   // Typed rows: error codes, extremes and plain results; the rest go through the slot table.
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // put to a free slot, null put, out-of-range put with all ignored fields high
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0001, 7'd0,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_BAD_PUT,   6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd64,  1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_BAD_PUT,   6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'hFF, 32'hFFFF_FFFF, 7'd127, 1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_BAD_PUT,   6'd0,  32'h0000_0000, 3'd0}},
      // claims: lowest inode, highest inode on the highest device, inode zero wraps
      '{'{icrt_pkg::OP_GET, 8'h00, 32'h0000_0001, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLAIM,     6'd1,  32'h1FFF_FFFF, 3'd6}},
      '{'{icrt_pkg::OP_GET, 8'h00, 32'h0000_0000, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLAIM,     6'd2,  32'h1FFF_FFFF, 3'd7}},
      // hit; same inode on another device is a different key
      '{'{icrt_pkg::OP_GET, 8'h00, 32'h0000_0001, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_HIT,       6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'h01, 32'h0000_0001, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLAIM,     6'd3,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_HIT,       6'd1,  32'h0000_0000, 3'd0}},
      // count 2 -> 1 -> 0 with write-back, then a put past zero
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd0,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_HELD,      6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd0,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_WRITEBACK, 6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd0,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_BAD_PUT,   6'd0,  32'h0000_0000, 3'd0}},
      // freed slot 0 is the lowest free one again
      '{'{icrt_pkg::OP_GET, 8'h07, 32'h1234_5678, 7'd0,   1'b0}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd2,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLEAN,     6'd2,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd1,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_HELD,      6'd1,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd1,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_WRITEBACK, 6'd1,  32'h1FFF_FFFF, 3'd6}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd63,  1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_BAD_PUT,   6'd63, 32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'h5A, 32'hA5A5_A5A5, 7'd0,   1'b0}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd3,   1'b1}, EXP_TYPED,
        '{icrt_pkg::STATUS_WRITEBACK, 6'd3,  32'h0000_0000, 3'd0}},
      // get ignores slot and dirty, put ignores device and inode
      '{'{icrt_pkg::OP_GET, 8'h80, 32'h0000_0008, 7'd127, 1'b1}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'hFF, 32'hFFFF_FFFF, 7'd2,   1'b0}, EXP_TYPED,
        '{icrt_pkg::STATUS_CLEAN,     6'd2,  32'h0000_0000, 3'd0}},
      // stale keys in freed slots must not hit
      '{'{icrt_pkg::OP_GET, 8'h00, 32'h0000_0001, 7'd0,   1'b0}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'h01, 32'h0000_0001, 7'd0,   1'b0}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_PUT, 8'h00, 32'h0000_0000, 7'd0,   1'b1}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_WRITEBACK, 6'd0,  32'h0000_0000, 3'd0}},
      '{'{icrt_pkg::OP_GET, 8'h07, 32'h1234_5678, 7'd0,   1'b0}, EXP_PREDICTED,
        '{icrt_pkg::STATUS_CLAIM,     6'd0,  32'h0000_0000, 3'd0}}
   };

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [icrt_pkg::START_W-1:0]   csr_wr_data;

   icrt_req_if req_chan ();
   icrt_rsp_if rsp_chan ();

   inode_cache_refcount_table_top #(.SLOT_COUNT(SLOT_COUNT)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the slot table and the start register
   logic [icrt_pkg::CNT_W-1:0]    held_count  [SLOT_COUNT];
   logic [icrt_pkg::DEV_W-1:0]    held_device [SLOT_COUNT];
   logic [icrt_pkg::INO_W-1:0]    held_inode  [SLOT_COUNT];
   logic [icrt_pkg::START_W-1:0]  start_block;

   // Keys reused by random gets so that hits and a full table are common
   logic [icrt_pkg::DEV_W-1:0]    key_dev [KEY_POOL];
   logic [icrt_pkg::INO_W-1:0]    key_ino [KEY_POOL];

   rsp_item_type        slot_rsp_q [$];   // results owed by the block, oldest first
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  hold_requests = 0; // bumped by stimulus only
   int                  holds_served = 0;  // receiver side only
   int                  hold_left = 0;

   // Block and in-block offset of an inode: eight inodes per block, so shift by 3.
   // Inode zero wraps to the last offset of block 0x1FFFFFFF past the start block.
   function automatic logic [icrt_pkg::BLOCK_W+icrt_pkg::OFFSET_W-1:0] inode_home(
      input logic [icrt_pkg::INO_W-1:0] ino);
      logic [icrt_pkg::INO_W-1:0] rel;
      rel = ino - 1'b1;
      return {(rel >> 3) + icrt_pkg::BLOCK_W'(start_block), rel[icrt_pkg::OFFSET_W-1:0]};
   endfunction

   // Applies one accepted item to the bench table and returns the result it owes.
   function automatic rsp_item_type slot_table_update(input req_item_type rq);
      rsp_item_type rsp;
      rsp = '0;
      if (rq.op == icrt_pkg::OP_GET) begin
         // match pass: live slots only
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (held_count[i] != 0 && held_device[i] == rq.dev && held_inode[i] == rq.ino) begin
               if (held_count[i] != icrt_pkg::COUNT_MAX)
                  held_count[i]++;           // saturates at the top
               rsp.status = icrt_pkg::STATUS_HIT;
               rsp.slot   = icrt_pkg::SLOTO_W'(i);
               return rsp;
            end
         end
         // free pass: lowest free slot
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (held_count[i] == 0) begin
               held_count[i]  = 1;
               held_device[i] = rq.dev;
               held_inode[i]  = rq.ino;
               rsp.status = icrt_pkg::STATUS_CLAIM;
               rsp.slot   = icrt_pkg::SLOTO_W'(i);
               {rsp.block, rsp.offset} = inode_home(rq.ino);
               return rsp;
            end
         end
         rsp.status = icrt_pkg::STATUS_FULL;
      end else if (rq.slot >= SLOT_COUNT) begin
         rsp.status = icrt_pkg::STATUS_BAD_PUT;  // null or out of range, slot_out stays zero
      end else begin
         rsp.slot = rq.slot[icrt_pkg::SLOTO_W-1:0];
         if (held_count[rq.slot] == 0) begin
            rsp.status = icrt_pkg::STATUS_BAD_PUT;  // repair: never goes below zero
         end else begin
            held_count[rq.slot]--;
            if (held_count[rq.slot] != 0) begin
               rsp.status = icrt_pkg::STATUS_HELD;
            end else if (!rq.dirty) begin
               rsp.status = icrt_pkg::STATUS_CLEAN;
            end else begin
               rsp.status = icrt_pkg::STATUS_WRITEBACK;
               {rsp.block, rsp.offset} = inode_home(held_inode[rq.slot]);
            end
         end
      end
      return rsp;
   endfunction

   // Random item. Unused fields always carry noise. Gets mostly use the key pool,
   // puts mostly name a live slot, the rest are random in-range or out-of-range slots.
   function automatic req_item_type random_request(input int get_pct);
      req_item_type rq;
      int           pick;
      int           base;
      rq.dev   = icrt_pkg::DEV_W'($urandom);
      rq.ino   = $urandom;
      rq.slot  = icrt_pkg::SLOTI_W'($urandom);
      rq.dirty = 1'($urandom);
      if ($urandom_range(99) < get_pct) begin
         rq.op = icrt_pkg::OP_GET;
         if ($urandom_range(99) < 85) begin
            pick   = $urandom_range(KEY_POOL - 1);
            rq.dev = key_dev[pick];
            rq.ino = key_ino[pick];
         end
      end else begin
         rq.op = icrt_pkg::OP_PUT;
         pick  = $urandom_range(99);
         if (pick < 85) begin
            base    = $urandom_range(SLOT_COUNT - 1);
            rq.slot = icrt_pkg::SLOTI_W'(base);
            for (int k = 0; k < SLOT_COUNT; k++) begin
               if (held_count[(base + k) % SLOT_COUNT] != 0) begin
                  rq.slot = icrt_pkg::SLOTI_W'((base + k) % SLOT_COUNT);
                  break;
               end
            end
         end else if (pick < 95) begin
            rq.slot = icrt_pkg::SLOTI_W'($urandom_range(SLOT_COUNT - 1));
         end else begin
            rq.slot = icrt_pkg::SLOTI_W'($urandom_range(127, SLOT_COUNT));
         end
      end
      return rq;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   // Within this task valid is only lowered by the idle loop, so it never drops and rises in one step.
   task automatic send_item(input req_item_type rq, input bit typed,
                            input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= rq.op;
      req_chan.device_id    <= rq.dev;
      req_chan.inode_number <= rq.ino;
      req_chan.slot_index   <= rq.slot;
      req_chan.dirty_flag   <= rq.dirty;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      predicted = slot_table_update(rq);
      slot_rsp_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Sender goes quiet until every owed result has come back.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do
         @(negedge clock);
      while (slot_rsp_q.size() != 0);
   endtask

   // New phase: block idle, write the start register, pick the idle pattern.
   task automatic begin_phase(input logic [icrt_pkg::START_W-1:0] value, input int snd_pct,
                              input int rcv_pct);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      start_block  = value;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
      send_idle_pct  = snd_pct;
      recv_idle_pct  = rcv_pct;
   endtask

   // Receiver: random stalls, or one long hold-off when stimulus asks for it.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         holds_served   <= holds_served + 1;
         hold_left      <= LONG_HOLD_CYCLES;
      end else if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result check: each taken result against the oldest owed one.
   always @(posedge clock) begin : check_results
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = '{rsp_chan.status, rsp_chan.slot_out, rsp_chan.disk_block,
                 rsp_chan.inode_offset};
         if (slot_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with none owed: status %0d slot %0d block %h offset %0d",
                        $time, got.status, got.slot, got.block, got.offset);
         end else begin
            want = slot_rsp_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: mismatch expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                           $time, want.status, want.slot, want.block, want.offset,
                           got.status, got.slot, got.block, got.offset);
            end
         end
      end
   end

   // Watchdog: CYCLE_LIMIT lies far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_item_type rq;
      int           free_slots;

      // every input known from time zero
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = icrt_pkg::OP_GET;
      req_chan.device_id    = '0;
      req_chan.inode_number = '0;
      req_chan.slot_index   = '0;
      req_chan.dirty_flag   = 1'b0;
      rsp_chan.ready        = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      start_block           = '0;
      foreach (held_count[i]) begin
         held_count[i]  = '0;
         held_device[i] = '0;
         held_inode[i]  = '0;
      end
      for (int k = 0; k < KEY_POOL; k++) begin
         key_dev[k] = icrt_pkg::DEV_W'($urandom);
         key_ino[k] = $urandom;
      end

      // phase A idling: sender 10%, receiver 46%
      send_idle_pct = 10;
      recv_idle_pct = 46;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // the clearing pass after reset keeps ready low; send_item just waits it out

      // directed items at the reset start value
      for (int n = 0; n < NUM_DIRECTED; n++)
         send_item(DIRECTED_ROWS[n].rq, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].rsp);

      // top start value; hammer one fresh key until its count pins at the maximum
      begin_phase({icrt_pkg::START_W{1'b1}}, 10, 46);
      rq     = random_request(100);
      rq.dev = icrt_pkg::DEV_W'($urandom);
      rq.ino = $urandom;
      repeat (int'(icrt_pkg::COUNT_MAX) + 2)
         send_item(rq, EXP_PREDICTED, '0);
      // one put off the saturated slot, which then stays held
      rq.op    = icrt_pkg::OP_PUT;
      rq.dirty = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (held_count[i] == icrt_pkg::COUNT_MAX)
            rq.slot = icrt_pkg::SLOTI_W'(i);
      send_item(rq, EXP_PREDICTED, '0);

      // fill the table with gets, then one more fresh key is refused as full
      do begin
         send_item(random_request(100), EXP_PREDICTED, '0);
         free_slots = 0;
         foreach (held_count[i])
            if (held_count[i] == 0)
               free_slots++;
      end while (free_slots != 0);
      rq     = random_request(100);
      rq.ino = $urandom;
      send_item(rq, EXP_PREDICTED, '0);
      repeat (50)
         send_item(random_request(60), EXP_PREDICTED, '0);

      // phase B idling: sender 46%, receiver 10%; mostly puts to drain the table
      begin_phase(icrt_pkg::START_W'($urandom), 46, 10);
      repeat (80)
         send_item(random_request(35), EXP_PREDICTED, '0);

      // start back at zero, get-heavy; one full pause and one long receiver hold-off
      begin_phase('0, 46, 10);
      for (int n = 0; n < 90; n++) begin
         if (n == 30)
            wait_for_results();
         if (n == 50)
            hold_requests++;   // sender keeps offering, block backs up behind the result
         send_item(random_request(65), EXP_PREDICTED, '0);
      end

      // no idling on either side
      begin_phase(icrt_pkg::START_W'($urandom), 0, 0);
      repeat (70)
         send_item(random_request(50), EXP_PREDICTED, '0);

      // drain, then give a stray result time to show up
      wait_for_results();
      repeat (SLOT_COUNT + 8) @(negedge clock);
      if (mismatch_count == 0 && slot_rsp_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
